>>> hw/rtl/drtms_pkg.sv
// ----------------------------------------------------------------------------
// drtms_pkg
// Types and constants shared by the DNS reply minimum-TTL scanner.
// ----------------------------------------------------------------------------
package drtms_pkg;

  localparam logic [31:0] CeilingReset   = 32'd3600;
  localparam logic [3:0]  HeaderLastIdx  = 4'd11;
  localparam logic [3:0]  RecordLastIdx  = 4'd11;
  localparam logic [3:0]  QSuffixLastIdx = 4'd3;
  localparam int          AddrWidth      = 3;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       is_last;
  } in_item_t;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_NO_RECORD = 2'd2
  } scan_status_t;

  typedef struct packed {
    logic [31:0] min_ttl;
    logic [1:0]  scan_status;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_QLABEL  = 3'd1,
    PH_QSKIP   = 3'd2,
    PH_QSUFFIX = 3'd3,
    PH_RFIXED  = 3'd4,
    PH_RDATA   = 3'd5,
    PH_DONE    = 3'd6,
    PH_NOREC   = 3'd7
  } phase_t;

  typedef struct packed {
    logic      load;
    out_item_t item;
  } result_t;

endpackage

>>> hw/rtl/drtms_cfg.sv
// ----------------------------------------------------------------------------
// drtms_cfg
// APB register file holding the TTL ceiling.
// ----------------------------------------------------------------------------
module drtms_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [drtms_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [31:0]                     ttl_ceiling
);
  import drtms_pkg::*;

  logic sel_ceiling;

  assign sel_ceiling = (paddr[AddrWidth-1:2] == '0);
  assign pready      = 1'b1;
  assign prdata      = sel_ceiling ? ttl_ceiling : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_ceiling <= CeilingReset;
    end else if (psel && penable && pwrite && pready && sel_ceiling) begin
      ttl_ceiling <= pwdata;
    end
  end

endmodule

>>> hw/rtl/drtms_parse.sv
// ----------------------------------------------------------------------------
// drtms_parse
// Input register and per-byte parse state update; emits one result per
// message on the last byte.
// ----------------------------------------------------------------------------
module drtms_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  drtms_pkg::in_item_t  byte_item,
  input  logic [31:0]          ttl_ceiling,
  input  logic                 slot_free,
  output drtms_pkg::result_t   result
);
  import drtms_pkg::*;

  logic        in_valid;
  in_item_t    in_item;
  logic        fire;

  phase_t      phase, phase_next, phase_eval;
  logic [3:0]  idx, idx_next;
  logic [15:0] questions_left, questions_left_next;
  logic [17:0] records_left, records_left_next;
  logic [15:0] skip_left, skip_left_next;
  logic [31:0] ttl_shift, ttl_shift_next;
  logic [31:0] running_min, running_min_next;

  logic [31:0] fin_min;
  logic [17:0] fin_records;
  phase_t      fin_phase;
  logic [7:0]  b;
  logic [15:0] skip_rec;

  assign b          = in_item.msg_byte;
  assign fire       = in_valid && (!in_item.is_last || slot_free);
  assign byte_ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_ready) begin
      in_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      in_item <= byte_item;
    end
  end

  // finish the current record
  always_comb begin
    fin_min     = ((ttl_shift != 32'd0) && (ttl_shift < running_min)) ? ttl_shift
                                                                      : running_min;
    fin_records = records_left - 18'd1;
    fin_phase   = (fin_records == 18'd0) ? PH_DONE : PH_RFIXED;
  end

  assign skip_rec = skip_left | {8'h00, b};

  always_comb begin
    phase_eval          = phase;
    idx_next            = idx;
    questions_left_next = questions_left;
    records_left_next   = records_left;
    skip_left_next      = skip_left;
    ttl_shift_next      = ttl_shift;
    running_min_next    = running_min;
    unique case (phase)
      PH_HEADER: begin
        if (idx == 4'd0) begin
          running_min_next    = ttl_ceiling;
          questions_left_next = '0;
          records_left_next   = '0;
          skip_left_next      = '0;
          ttl_shift_next      = '0;
        end
        if (idx == 4'd4 || idx == 4'd5) begin
          questions_left_next = {questions_left[7:0], b};
        end else if (idx == 4'd6 || idx == 4'd8 || idx == 4'd10) begin
          skip_left_next = {b, 8'h00};
        end else if (idx == 4'd7 || idx == 4'd9 || idx == 4'd11) begin
          records_left_next = records_left + {2'b00, skip_rec};
          skip_left_next    = '0;
        end
        if (idx == HeaderLastIdx) begin
          idx_next = 4'd0;
          if (records_left_next == 18'd0) begin
            phase_eval = PH_NOREC;
          end else if (questions_left_next != 16'd0) begin
            phase_eval = PH_QLABEL;
          end else begin
            phase_eval = PH_RFIXED;
          end
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_QLABEL: begin
        if (b == 8'd0) begin
          idx_next   = 4'd0;
          phase_eval = PH_QSUFFIX;
        end else begin
          skip_left_next = {8'h00, b};
          phase_eval     = PH_QSKIP;
        end
      end
      PH_QSKIP: begin
        skip_left_next = skip_left - 16'd1;
        if (skip_left_next == 16'd0) begin
          phase_eval = PH_QLABEL;
        end
      end
      PH_QSUFFIX: begin
        if (idx == QSuffixLastIdx) begin
          idx_next            = 4'd0;
          questions_left_next = questions_left - 16'd1;
          phase_eval = (questions_left_next != 16'd0) ? PH_QLABEL : PH_RFIXED;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_RFIXED: begin
        if (idx >= 4'd6 && idx <= 4'd9) begin
          ttl_shift_next = {ttl_shift[23:0], b};
        end else if (idx == 4'd10) begin
          skip_left_next = {b, 8'h00};
        end else if (idx == RecordLastIdx) begin
          skip_left_next = skip_rec;
        end
        if (idx == RecordLastIdx) begin
          idx_next = 4'd0;
          if (skip_left_next == 16'd0) begin
            running_min_next  = fin_min;
            records_left_next = fin_records;
            phase_eval        = fin_phase;
          end else begin
            phase_eval = PH_RDATA;
          end
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_RDATA: begin
        skip_left_next = skip_left - 16'd1;
        if (skip_left_next == 16'd0) begin
          idx_next          = 4'd0;
          running_min_next  = fin_min;
          records_left_next = fin_records;
          phase_eval        = fin_phase;
        end
      end
      PH_DONE, PH_NOREC: begin
      end
      default: begin
      end
    endcase

    phase_next = phase_eval;
    if (in_item.is_last) begin
      phase_next = PH_HEADER;
      idx_next   = 4'd0;
    end

    result.load = fire && in_item.is_last;
    unique case (phase_eval)
      PH_NOREC: begin
        result.item.min_ttl     = '1;
        result.item.scan_status = ST_NO_RECORD;
      end
      PH_DONE: begin
        result.item.min_ttl     = running_min_next;
        result.item.scan_status = ST_COMPLETE;
      end
      default: begin
        result.item.min_ttl     = running_min_next;
        result.item.scan_status = ST_TRUNCATED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      idx            <= '0;
      questions_left <= '0;
      records_left   <= '0;
      skip_left      <= '0;
      ttl_shift      <= '0;
      running_min    <= CeilingReset;
    end else if (fire) begin
      phase          <= phase_next;
      idx            <= idx_next;
      questions_left <= questions_left_next;
      records_left   <= records_left_next;
      skip_left      <= skip_left_next;
      ttl_shift      <= ttl_shift_next;
      running_min    <= running_min_next;
    end
  end

endmodule

>>> hw/rtl/drtms_out.sv
// ----------------------------------------------------------------------------
// drtms_out
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module drtms_out (
  input  logic                 clk,
  input  logic                 rst,
  input  drtms_pkg::result_t   result,
  output logic                 slot_free,
  output logic                 res_valid,
  input  logic                 res_ready,
  output drtms_pkg::out_item_t res_item
);
  import drtms_pkg::*;

  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (slot_free) begin
      res_valid <= result.load;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && result.load) begin
      res_item <= result.item;
    end
  end

endmodule

>>> hw/rtl/dns_reply_min_ttl_scan.sv
// ----------------------------------------------------------------------------
// dns_reply_min_ttl_scan
// Scans a DNS reply byte stream and reports the smallest non-zero record TTL,
// capped by a programmable ceiling.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// byte      in         byte_valid/byte_ready  in_item_t  (msg_byte, is_last)
// res       out        res_valid/res_ready    out_item_t (min_ttl, scan_status)
// apb       in         psel/penable/pready    ttl_ceiling at byte address 0
//
// One byte per cycle is taken while no last byte is stalled; the input register
// feeds the parse state update, which loads the result register once the
// last byte leaves the input register and the result register is free.
// The parse state update is combinational.
// A result waiting in the output register stalls only a last byte; other
// bytes keep flowing.
// Reset is synchronous; the ceiling returns to 3600.
// ----------------------------------------------------------------------------
module dns_reply_min_ttl_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  drtms_pkg::in_item_t             byte_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output drtms_pkg::out_item_t            res_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [drtms_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import drtms_pkg::*;

  logic [31:0] ttl_ceiling;
  logic        slot_free;
  result_t     result;

  drtms_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .ttl_ceiling (ttl_ceiling)
  );

  drtms_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .ttl_ceiling (ttl_ceiling),
    .slot_free   (slot_free),
    .result      (result)
  );

  drtms_out u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

>>> hw/rtl/drtms_checker.sv
// ----------------------------------------------------------------------------
// drtms_checker
// Port-level checks for the DNS reply minimum-TTL scanner.
// ----------------------------------------------------------------------------
module drtms_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input drtms_pkg::out_item_t res_item
);
  import drtms_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.scan_status != 2'd3)
    else $error("undefined scan status");

  a_norec_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.scan_status == ST_NO_RECORD |-> res_item.min_ttl == '1)
    else $error("no-records result without all-ones TTL");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind dns_reply_min_ttl_scan drtms_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);
